// File: hw/rtl/ltgf_pkg.sv
package ltgf_pkg;

  // Pattern storage and name length limits
  localparam int PatMax   = 16;
  localparam int PosW     = PatMax + 1;
  localparam int LenW     = $clog2(PatMax + 1);
  localparam int LenRegW  = 5;
  localparam int LenLimit = 255;
  localparam int CntW     = $clog2(LenLimit + 1);
  localparam int NameW    = 8;
  localparam int CharW    = 8;
  localparam int RegW     = 64;

  // Command queue between front and back
  localparam int QDepth = 2;

  // Configuration register indexes (byte address bits [4:3])
  localparam int AddrW  = 5;
  localparam int RegIdxW = 2;
  localparam logic [RegIdxW-1:0] RegCharsLow  = 2'd0;
  localparam logic [RegIdxW-1:0] RegCharsHigh = 2'd1;
  localparam logic [RegIdxW-1:0] RegLength    = 2'd2;

  // Character codes
  localparam logic [CharW-1:0] CharStar   = 8'h2A;
  localparam logic [CharW-1:0] CharQuest  = 8'h3F;
  localparam logic [CharW-1:0] CharBslash = 8'h5C;
  localparam logic [CharW-1:0] CharSpace  = 8'h20;
  localparam logic [CharW-1:0] CharSlash  = 8'h2F;
  localparam logic [CharW-1:0] CharUpA    = 8'h41;
  localparam logic [CharW-1:0] CharUpZ    = 8'h5A;
  localparam logic [CharW-1:0] CaseDelta  = 8'h20;

  typedef logic [PatMax-1:0][CharW-1:0] pat_chars_t;

  // One classified command from the front: append a character, close the name, or both
  typedef struct packed {
    logic             append;
    logic             close;
    logic [CharW-1:0] ch;
  } cmd_t;

  function automatic logic [CharW-1:0] fold(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= CharUpA && c <= CharUpZ) begin
      r = c + CaseDelta;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/ltgf_front.sv
module ltgf_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      text_valid,
  output logic                      text_ready,
  input  logic [ltgf_pkg::CharW-1:0] text_byte,
  input  logic                      final_byte,
  input  logic                      queue_full,
  output logic                      cmd_push,
  output ltgf_pkg::cmd_t            cmd
);
  import ltgf_pkg::*;

  logic escape_pending;
  logic escape_pending_next;
  logic accept;

  assign text_ready = !queue_full;
  assign accept     = text_valid && text_ready;

  // Classify the byte; a lone backslash produces no command unless it is final
  always_comb begin
    cmd.ch     = text_byte;
    cmd.append = 1'b0;
    cmd.close  = final_byte;
    if (escape_pending) begin
      cmd.append = 1'b1;
    end else if (text_byte == CharBslash) begin
      cmd.append = 1'b0;
    end else if (text_byte == CharSpace) begin
      cmd.close = 1'b1;
    end else begin
      cmd.append = 1'b1;
    end
  end

  assign cmd_push = accept && (cmd.append || cmd.close);

  always_comb begin
    escape_pending_next = escape_pending;
    if (accept) begin
      if (final_byte || escape_pending) begin
        escape_pending_next = 1'b0;
      end else begin
        escape_pending_next = (text_byte == CharBslash);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
    end else begin
      escape_pending <= escape_pending_next;
    end
  end

endmodule

// File: hw/rtl/ltgf_queue.sv
module ltgf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ltgf_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output ltgf_pkg::cmd_t pop_data
);
  import ltgf_pkg::*;

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW = $clog2(QDepth + 1);

  cmd_t             slots [QDepth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [QCntW-1:0] count;

  assign full      = (count == QCntW'(QDepth));
  assign pop_valid = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QDepth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QDepth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + QCntW'(1);
      end else if (pop && !push) begin
        count <= count - QCntW'(1);
      end
    end
  end

endmodule

// File: hw/rtl/ltgf_back.sv
module ltgf_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ltgf_pkg::pat_chars_t          pat_chars,
  input  logic [ltgf_pkg::LenRegW-1:0]  pat_len,
  input  logic                          cmd_valid,
  input  ltgf_pkg::cmd_t                cmd,
  output logic                          cmd_pop,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic                          selected,
  output logic                          pattern_hit,
  output logic                          is_directory,
  output logic [ltgf_pkg::NameW-1:0]    name_length
);
  import ltgf_pkg::*;

  // Star closure: position j is live if some live i <= j is followed only by stars up to j
  function automatic logic [PosW-1:0] close_stars(input logic [PosW-1:0] act,
                                                  input logic [PatMax-1:0] star);
    logic [PosW-1:0] res;
    logic            run;
    for (int j = 0; j < PosW; j++) begin
      res[j] = act[j];
      run    = 1'b1;
      for (int i = j - 1; i >= 0; i--) begin
        run    = run & star[i];
        res[j] = res[j] | (act[i] & run);
      end
    end
    return res;
  endfunction

  logic [PosW-1:0]   active;
  logic              inside_name;
  logic              last_was_slash;
  logic [CntW-1:0]   length_count;

  logic [LenW-1:0]   eff_len;
  logic [PatMax-1:0] in_pat;
  logic [PatMax-1:0] star;
  logic [PosW-1:0]   cur;
  logic [PosW-1:0]   stepped;
  logic [PosW-1:0]   after;
  logic [PosW-1:0]   after_closed;
  logic              inside_after;
  logic              slash_after;
  logic [CntW-1:0]   len_after;
  logic              hit;
  logic              emit;
  logic              out_free;

  always_comb begin
    if (int'(pat_len) > PatMax) begin
      eff_len = LenW'(PatMax);
    end else begin
      eff_len = LenW'(pat_len);
    end
    for (int i = 0; i < PatMax; i++) begin
      in_pat[i] = (int'(eff_len) > i);
      star[i]   = in_pat[i] && (pat_chars[i] == CharStar);
    end
  end

  // Advance the position set by one character
  always_comb begin
    cur     = close_stars(active, star);
    stepped = '0;
    for (int i = 0; i < PatMax; i++) begin
      if (cur[i] && in_pat[i]) begin
        if (star[i]) begin
          stepped[i] = 1'b1;
        end else if (pat_chars[i] == CharQuest || fold(pat_chars[i]) == fold(cmd.ch)) begin
          stepped[i+1] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    after        = cmd.append ? stepped : active;
    after_closed = close_stars(after, star);
    hit          = after_closed[eff_len];
    inside_after = cmd.append || inside_name;
    slash_after  = cmd.append ? (cmd.ch == CharSlash) : last_was_slash;
    len_after    = length_count;
    if (cmd.append && length_count < CntW'(LenLimit)) begin
      len_after = length_count + CntW'(1);
    end
  end

  assign emit     = cmd.close && inside_after;
  assign out_free = !result_valid || result_ready;
  assign cmd_pop  = cmd_valid && (!emit || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= PosW'(1);
      inside_name    <= 1'b0;
      last_was_slash <= 1'b0;
      length_count   <= '0;
    end else if (cmd_pop) begin
      if (cmd.close) begin
        active         <= PosW'(1);
        inside_name    <= 1'b0;
        last_was_slash <= 1'b0;
        length_count   <= '0;
      end else begin
        active         <= after;
        inside_name    <= inside_after;
        last_was_slash <= slash_after;
        length_count   <= len_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd_pop && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && emit) begin
      selected     <= hit && !slash_after;
      pattern_hit  <= hit;
      is_directory <= slash_after;
      name_length  <= NameW'(len_after);
    end
  end

endmodule

// File: hw/rtl/listing_token_glob_filter.sv
// Listing name filter with case-insensitive wildcard match.
// A name's result is registered when its closing byte leaves the queue; a byte taken
// from the stream is first written into the queue on its way to the back stage.
// Throughput: one text byte per cycle while the queue is not full; the position-set update
// and its star closure are combinational logic in the back stage. Reset (rst, synchronous) clears the
// pattern registers, the escape flag, the queue, the name state and result_valid.
module listing_token_glob_filter (
  input  logic                          clk,
  input  logic                          rst,
  // listing byte stream
  input  logic                          text_valid,
  output logic                          text_ready,
  input  logic [ltgf_pkg::CharW-1:0]    text_byte,
  input  logic                          final_byte,
  // one transaction per completed name
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic                          selected,
  output logic                          pattern_hit,
  output logic                          is_directory,
  output logic [ltgf_pkg::NameW-1:0]    name_length,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ltgf_pkg::AddrW-1:0]    paddr,
  input  logic [ltgf_pkg::RegW-1:0]     pwdata,
  output logic [ltgf_pkg::RegW-1:0]     prdata,
  output logic                          pready
);
  import ltgf_pkg::*;

  logic [RegW-1:0]    pattern_chars_low;
  logic [RegW-1:0]    pattern_chars_high;
  logic [LenRegW-1:0] pattern_length;
  logic [RegIdxW-1:0] reg_idx;
  logic               cfg_write;
  pat_chars_t         pat_chars;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic cmd_push;
  logic cmd_pop;
  logic queue_full;
  logic cmd_valid;

  // Registers sit at 8-byte strides; low address bits are ignored
  assign pready    = 1'b1;
  assign reg_idx   = paddr[AddrW-1:AddrW-RegIdxW];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_chars_low  <= '0;
      pattern_chars_high <= '0;
      pattern_length     <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        RegCharsLow:  pattern_chars_low  <= pwdata;
        RegCharsHigh: pattern_chars_high <= pwdata;
        RegLength:    pattern_length     <= pwdata[LenRegW-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegCharsLow:  prdata = pattern_chars_low;
      RegCharsHigh: prdata = pattern_chars_high;
      RegLength:    prdata = RegW'(pattern_length);
      default:      prdata = '0;
    endcase
  end

  // Unpack pattern bytes, first character in the low byte; slots past the registers read zero
  always_comb begin
    for (int i = 0; i < PatMax; i++) begin
      if (i < 8) begin
        pat_chars[i] = pattern_chars_low[8*(i%8) +: CharW];
      end else if (i < 16) begin
        pat_chars[i] = pattern_chars_high[8*(i%8) +: CharW];
      end else begin
        pat_chars[i] = '0;
      end
    end
  end

  // Front: strip escapes, turn bytes into append/close commands
  ltgf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .queue_full (queue_full),
    .cmd_push   (cmd_push),
    .cmd        (front_cmd)
  );

  // Decouple the front from result backpressure
  ltgf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (front_cmd),
    .full      (queue_full),
    .pop       (cmd_pop),
    .pop_valid (cmd_valid),
    .pop_data  (back_cmd)
  );

  // Back: advance the active-position set, count length, register the result
  ltgf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pat_chars    (pat_chars),
    .pat_len      (pattern_length),
    .cmd_valid    (cmd_valid),
    .cmd          (back_cmd),
    .cmd_pop      (cmd_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .selected     (selected),
    .pattern_hit  (pattern_hit),
    .is_directory (is_directory),
    .name_length  (name_length)
  );

endmodule

// File: bench/name_result_checker.sv
module name_result_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         text_valid,
  input  logic                         text_ready,
  input  logic [ltgf_pkg::CharW-1:0]   text_byte,
  input  logic                         final_byte,
  input  logic                         result_valid,
  input  logic                         result_ready,
  input  logic                         selected,
  input  logic                         pattern_hit,
  input  logic                         is_directory,
  input  logic [ltgf_pkg::NameW-1:0]   name_length,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [ltgf_pkg::AddrW-1:0]   paddr,
  input  logic [ltgf_pkg::RegW-1:0]    pwdata,
  output int                           errors,
  output int                           pending,
  output int                           names_seen,
  output int                           hits_seen,
  output int                           dirs_seen,
  output int                           full_len_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import ltgf_pkg::*;

  typedef struct packed {
    logic             sel;
    logic             hit;
    logic             dir;
    logic [NameW-1:0] len;
  } name_result_t;

  name_result_t     expected_names[$];

  // Shadow of the pattern registers
  logic [CharW-1:0]   pat [PatMax];
  logic [LenRegW-1:0] pat_len;

  // Shadow of the name state
  logic [PosW-1:0]    reached;
  logic               esc_pending;
  logic               in_name;
  logic               ends_slash;
  logic [NameW-1:0]   char_count;

  function automatic int used_len();
    return (pat_len > PatMax) ? PatMax : int'(pat_len);
  endfunction

  function automatic logic [CharW-1:0] to_lower(input logic [CharW-1:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
  endfunction

  // A star at position i also makes position i+1 reachable
  function automatic logic [PosW-1:0] expand_stars(input logic [PosW-1:0] s);
    logic [PosW-1:0] r;
    r = s;
    for (int i = 0; i < used_len(); i++) begin
      if (r[i] && pat[i] == CharStar) begin
        r[i+1] = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic clear_name();
    reached    = PosW'(1);
    in_name    = 1'b0;
    ends_slash = 1'b0;
    char_count = '0;
  endtask

  task automatic append_char(input logic [CharW-1:0] c);
    logic [PosW-1:0] cur;
    logic [PosW-1:0] nxt;
    cur = expand_stars(reached);
    nxt = '0;
    for (int i = 0; i < used_len(); i++) begin
      if (cur[i]) begin
        if (pat[i] == CharStar) begin
          nxt[i] = 1'b1;
        end else if (pat[i] == CharQuest || to_lower(pat[i]) == to_lower(c)) begin
          nxt[i+1] = 1'b1;
        end
      end
    end
    reached    = nxt;
    in_name    = 1'b1;
    ends_slash = (c == CharSlash);
    if (char_count < LenLimit) begin
      char_count++;
    end
  endtask

  task automatic close_name();
    logic [PosW-1:0] cur;
    logic            hit;
    cur = expand_stars(reached);
    hit = cur[used_len()];
    expected_names.push_back({hit && !ends_slash, hit, ends_slash, char_count});
  endtask

  task automatic take_byte(input logic [CharW-1:0] c, input logic fin);
    logic closed;
    closed = 1'b0;
    if (esc_pending) begin
      esc_pending = 1'b0;
      append_char(c);
    end else if (c == CharBslash) begin
      esc_pending = 1'b1;
    end else if (c == CharSpace) begin
      if (in_name) begin
        close_name();
        closed = 1'b1;
      end
      clear_name();
    end else begin
      append_char(c);
    end
    if (fin) begin
      if (!closed && in_name) begin
        close_name();
      end
      esc_pending = 1'b0;
      clear_name();
    end
  endtask

  task automatic report(input string what, input int want_v, input int got_v);
    errors++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin : watch
    name_result_t want;
    name_result_t got;
    if (rst) begin
      foreach (pat[i]) begin
        pat[i] = '0;
      end
      pat_len       = '0;
      esc_pending   = 1'b0;
      clear_name();
      expected_names.delete();
      errors        = 0;
      names_seen    = 0;
      hits_seen     = 0;
      dirs_seen     = 0;
      full_len_seen = 0;
    end else begin
      if (result_valid && result_ready) begin
        got = {selected, pattern_hit, is_directory, name_length};
        names_seen++;
        if (expected_names.size() == 0) begin
          errors++;
          $display("%0t: unexpected name result sel=%0b hit=%0b dir=%0b len=%0d",
                   $time, got.sel, got.hit, got.dir, got.len);
        end else begin
          want = expected_names.pop_front();
          if (got.sel !== want.sel) report("selected", want.sel, got.sel);
          if (got.hit !== want.hit) report("pattern_hit", want.hit, got.hit);
          if (got.dir !== want.dir) report("is_directory", want.dir, got.dir);
          if (got.len !== want.len) report("name_length", want.len, got.len);
          if (want.hit) hits_seen++;
          if (want.dir) dirs_seen++;
          if (want.len == LenLimit) full_len_seen++;
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[AddrW-1 -: RegIdxW])
          RegCharsLow: begin
            for (int i = 0; i < 8; i++) pat[i] = pwdata[8*i +: 8];
          end
          RegCharsHigh: begin
            for (int i = 0; i < 8; i++) pat[8+i] = pwdata[8*i +: 8];
          end
          RegLength: begin
            pat_len = pwdata[LenRegW-1:0];
          end
          default: begin
          end
        endcase
      end
      if (text_valid && text_ready) begin
        take_byte(text_byte, final_byte);
      end
    end
    pending = expected_names.size();
  end

endmodule

// File: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ltgf_pkg::*;

  // Random bytes per pattern setting, number of settings, drain margin
  localparam int SegItems    = 80;
  localparam int SegCount    = 9;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 400000;

  logic               clk;
  logic               rst;
  logic               text_valid;
  logic               text_ready;
  logic [CharW-1:0]   text_byte;
  logic               final_byte;
  logic               result_valid;
  logic               result_ready;
  logic               selected;
  logic               pattern_hit;
  logic               is_directory;
  logic [NameW-1:0]   name_length;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [AddrW-1:0]   paddr;
  logic [RegW-1:0]    pwdata;
  logic [RegW-1:0]    prdata;
  logic               pready;

  int errors;
  int pending;
  int names_seen;
  int hits_seen;
  int dirs_seen;
  int full_len_seen;

  // Idle rates in percent, per cycle
  int send_idle;
  int recv_idle;
  int bytes_sent;
  int patterns_loaded;
  int cycles;

  // Pattern currently programmed, kept to steer names toward hits
  logic [CharW-1:0]   pat_tb [PatMax];
  logic [LenRegW-1:0] pat_len_tb;
  logic [CharW-1:0]   name_q[$];

  listing_token_glob_filter uut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_byte    (text_byte),
    .final_byte   (final_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .selected     (selected),
    .pattern_hit  (pattern_hit),
    .is_directory (is_directory),
    .name_length  (name_length),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  name_result_checker name_check (
    .clk           (clk),
    .rst           (rst),
    .text_valid    (text_valid),
    .text_ready    (text_ready),
    .text_byte     (text_byte),
    .final_byte    (final_byte),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .selected      (selected),
    .pattern_hit   (pattern_hit),
    .is_directory  (is_directory),
    .name_length   (name_length),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .errors        (errors),
    .pending       (pending),
    .names_seen    (names_seen),
    .hits_seen     (hits_seen),
    .dirs_seen     (dirs_seen),
    .full_len_seen (full_len_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall at the configured rate, decided fresh at every falling edge
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog: end the run as failed once the cycle limit is reached
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("listing_token_glob_filter test failed");
    $finish;
  end

  // Present one byte and hold it until the transaction completes. Insert
  // random gaps first; each gap drops valid for one full cycle.
  task automatic send_byte(input logic [CharW-1:0] b, input logic fin);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      text_valid <= 1'b0;
      @(negedge clk);
    end
    text_valid <= 1'b1;
    text_byte  <= b;
    final_byte <= fin;
    @(posedge clk);
    while (!text_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input logic fin_last);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], fin_last && (i == s.len() - 1));
    end
  endtask

  // Setup cycle, then access cycle; the write lands at the edge where pready is seen
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [RegW-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_pattern();
    logic [RegW-1:0] lo;
    logic [RegW-1:0] hi;
    logic [RegW-1:0] len_word;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = pat_tb[i];
      hi[8*i +: 8] = pat_tb[8+i];
    end
    // Upper bits of the length word carry noise; only the low field counts
    len_word                = {$urandom(), $urandom()};
    len_word[LenRegW-1:0]   = pat_len_tb;
    write_reg(RegCharsLow, lo);
    write_reg(RegCharsHigh, hi);
    write_reg(RegLength, len_word);
    patterns_loaded++;
  endtask

  // Drop valid, wait for every outstanding name result, then let the
  // pipeline settle so bytes that close no name have left the queue too
  task automatic wait_idle();
    @(negedge clk);
    text_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic logic [CharW-1:0] random_char();
    string alphabet;
    alphabet = "aBcXyZ.tT_09-";
    if ($urandom_range(99) < 15) begin
      return CharW'($urandom_range(255));
    end
    return alphabet[$urandom_range(alphabet.len() - 1)];
  endfunction

  function automatic logic [CharW-1:0] pattern_char();
    int r;
    r = $urandom_range(99);
    if (r < 15) return CharStar;
    if (r < 25) return CharQuest;
    return random_char();
  endfunction

  // Choose the pattern for one setting; a few settings pin the extremes
  task automatic pick_pattern(input int seg);
    foreach (pat_tb[i]) begin
      pat_tb[i] = pattern_char();
    end
    case (seg)
      1: pat_len_tb = '0;                       // empty pattern: nothing hits
      2: pat_len_tb = '1;                       // length past the pattern size
      3: begin
        foreach (pat_tb[i]) pat_tb[i] = '1;     // all ones, full length
        pat_len_tb = LenRegW'(PatMax);
      end
      4: begin
        foreach (pat_tb[i]) pat_tb[i] = '0;     // zero bytes as plain characters
        pat_len_tb = LenRegW'(PatMax);
      end
      default: pat_len_tb = LenRegW'($urandom_range(1, PatMax));
    endcase
  endtask

  // Build one name: mostly an instance of the pattern with random case and
  // random star runs, sometimes mutated, sometimes random, rarely very long
  function automatic void build_name();
    int               n_eff;
    int               r;
    logic [CharW-1:0] p;
    logic [CharW-1:0] up;
    n_eff = (pat_len_tb > PatMax) ? PatMax : int'(pat_len_tb);
    name_q.delete();
    r = $urandom_range(99);
    if (r < 2) begin
      repeat ($urandom_range(250, 300)) name_q.push_back(random_char());
    end else if (r < 60) begin
      for (int i = 0; i < n_eff; i++) begin
        p  = pat_tb[i];
        up = p & ~CaseDelta;
        if (p == CharStar) begin
          repeat ($urandom_range(0, 3)) name_q.push_back(random_char());
        end else if (p == CharQuest) begin
          name_q.push_back(CharW'($urandom_range(255)));
        end else if (up >= CharUpA && up <= CharUpZ && $urandom_range(1) == 1) begin
          name_q.push_back(p ^ CaseDelta);
        end else begin
          name_q.push_back(p);
        end
      end
      if (name_q.size() > 0 && $urandom_range(99) < 20) begin
        name_q[$urandom_range(name_q.size() - 1)] = random_char();
      end
    end else begin
      repeat ($urandom_range(1, 12)) name_q.push_back(random_char());
    end
    if ($urandom_range(99) < 15) begin
      name_q.push_back(CharSlash);
    end
  endfunction

  // Send a name with escapes where needed (and now and then where not),
  // then end it: final on its last byte, space with final, a dangling
  // backslash with final, or a run of spaces
  task automatic send_name();
    int t;
    build_name();
    t = $urandom_range(99);
    foreach (name_q[i]) begin
      if (name_q[i] == CharSpace || name_q[i] == CharBslash || $urandom_range(99) < 4) begin
        send_byte(CharBslash, 1'b0);
      end
      send_byte(name_q[i], (t < 8) && (i == name_q.size() - 1));
    end
    if (t < 8) begin
    end else if (t < 12) begin
      send_byte(CharSpace, 1'b1);
    end else if (t < 15) begin
      send_byte(CharBslash, 1'b1);
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(CharSpace, 1'b0);
    end
  endtask

  initial begin
    int target;
    int seg;
    rst             = 1'b1;
    text_valid      = 1'b0;
    text_byte       = '0;
    final_byte      = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    send_idle       = 14;
    recv_idle       = 79;
    bytes_sent      = 0;
    patterns_loaded = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: pattern with star, question mark and mixed case
    foreach (pat_tb[i]) pat_tb[i] = pattern_char();
    pat_tb[0]  = CharStar;
    pat_tb[1]  = ".";
    pat_tb[2]  = "T";
    pat_tb[3]  = CharQuest;
    pat_tb[4]  = "t";
    pat_len_tb = LenRegW'(5);
    program_pattern();

    // Leading and repeated spaces, a case-folded hit, a directory
    send_text(" A.TXT  d/ ", 1'b0);
    // Escaped space and escaped backslash inside a name
    send_text("a\\ \\\\.txt", 1'b0);
    // Space carrying the final flag closes the name once
    send_byte(CharSpace, 1'b1);
    // Zero byte, non-ASCII bytes, then a backslash as the final byte
    send_byte(8'h00, 1'b0);
    send_byte(8'hC1, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CharBslash, 1'b1);

    // Random: three idling modes, three pattern settings in each
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 14; recv_idle = 79; end
        1: begin send_idle = 79; recv_idle = 14; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int sg = 0; sg < SegCount / 3; sg++) begin
        seg = phase * (SegCount / 3) + sg;
        // Leave a name open so the new pattern reads the positions reached so far
        send_byte(random_char() | 8'h40, 1'b0);
        send_byte("k", 1'b0);
        wait_idle();
        pick_pattern(seg);
        program_pattern();
        target = bytes_sent + SegItems;
        while (bytes_sent < target) begin
          if ($urandom_range(99) < 8) begin
            send_byte(CharW'($urandom_range(255)), $urandom_range(99) < 5);
          end else begin
            send_name();
          end
          // Now and then hold off until every outstanding result has come back
          if ($urandom_range(99) == 0) begin
            wait_idle();
          end
        end
      end
    end

    // Flush the last open name and drain
    send_byte(CharSpace, 1'b1);
    wait_idle();

    $display("Sent %0d listing bytes; checked %0d names: %0d hits, %0d directories, %0d at %0d",
             bytes_sent, names_seen, hits_seen, dirs_seen, full_len_seen, LenLimit);
    $display("Used %0d pattern settings with sender-side, receiver-side and no idling",
             patterns_loaded);
    if (errors == 0 && pending == 0) begin
      $display("listing_token_glob_filter test passed");
    end else begin
      $display("listing_token_glob_filter test failed");
    end
    $finish;
  end

endmodule
